// ----- hw/rtl/cse_pkg.sv -----
package cse_pkg;

  // one raw string byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // one character of escaped text
  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
  } out_item_t;

  // classified byte: up to four characters, last_idx is count minus one
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][6:0] chars;
  } token_t;

  // token queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [6:0] CharBslash = 7'h5C;
  localparam logic [6:0] CharX      = 7'h78;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [7:0] BytePrintLo = 8'h20;
  localparam logic [7:0] BytePrintHi = 8'h7E;

  localparam logic [1:0] LenOne  = 2'd0;
  localparam logic [1:0] LenTwo  = 2'd1;
  localparam logic [1:0] LenFour = 2'd3;

  // letter after the backslash for a simple escape, zero if none
  function automatic logic [6:0] simple_escape(input logic [7:0] b);
    logic [6:0] esc;
    unique case (b)
      8'h27:   esc = 7'h27;
      8'h22:   esc = 7'h22;
      8'h3F:   esc = 7'h3F;
      8'h5C:   esc = 7'h5C;
      8'h07:   esc = 7'h61;
      8'h08:   esc = 7'h62;
      8'h0C:   esc = 7'h66;
      8'h0A:   esc = 7'h6E;
      8'h0D:   esc = 7'h72;
      8'h09:   esc = 7'h74;
      8'h0B:   esc = 7'h76;
      default: esc = 7'h00;
    endcase
    return esc;
  endfunction

  // lower-case hex digit
  function automatic logic [6:0] hex_digit(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) begin
      c = 7'h30 + {3'b000, v};
    end else begin
      c = 7'h57 + {3'b000, v};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/cse_front.sv -----
module cse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cse_pkg::in_item_t item_i,
  input  logic              counted_mode_i,
  output logic              tok_push_o,
  output cse_pkg::token_t   tok_o,
  output logic              stopped_o
);
  import cse_pkg::*;

  logic       stopped_q, stopped_d;
  logic       is_nul;
  logic [6:0] esc;
  logic       emits;

  assign is_nul = (item_i.in_byte == 8'h00);
  assign esc    = simple_escape(item_i.in_byte);

  always_comb begin
    tok_o = '0;
    emits = 1'b1;
    if (is_nul) begin
      tok_o.last_idx = LenTwo;
      tok_o.chars[0] = CharBslash;
      tok_o.chars[1] = CharZero;
      emits          = counted_mode_i;
    end else if (esc != 7'h00) begin
      tok_o.last_idx = LenTwo;
      tok_o.chars[0] = CharBslash;
      tok_o.chars[1] = esc;
    end else if (item_i.in_byte >= BytePrintLo && item_i.in_byte <= BytePrintHi) begin
      tok_o.last_idx = LenOne;
      tok_o.chars[0] = item_i.in_byte[6:0];
    end else begin
      tok_o.last_idx = LenFour;
      tok_o.chars[0] = CharBslash;
      tok_o.chars[1] = CharX;
      tok_o.chars[2] = hex_digit(item_i.in_byte[7:4]);
      tok_o.chars[3] = hex_digit(item_i.in_byte[3:0]);
    end
  end

  assign tok_push_o = accept_i && !stopped_q && emits;
  assign stopped_o  = stopped_q;

  always_comb begin
    stopped_d = stopped_q;
    if (accept_i) begin
      if (item_i.in_last) begin
        stopped_d = 1'b0;
      end else if (!stopped_q && is_nul && !counted_mode_i) begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
    end else begin
      stopped_q <= stopped_d;
    end
  end

endmodule

// ----- hw/rtl/cse_queue.sv -----
module cse_queue #(
  parameter int QDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cse_pkg::token_t   tok_i,
  input  logic              pop_i,
  output cse_pkg::token_t   head_o,
  output cse_pkg::q_stat_t  stat_o
);
  import cse_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  token_t            slots_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// ----- hw/rtl/cse_back.sv -----
module cse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cse_pkg::token_t    head_i,
  input  cse_pkg::q_stat_t   q_stat_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  output cse_pkg::out_item_t out_item_o,
  input  logic               out_take_i
);
  import cse_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;
  logic       load;
  logic       at_end;

  // refill the output register from a waiting token whenever it is free or being drained
  assign load    = !q_stat_i.empty && (!out_valid_q || out_take_i);
  assign at_end  = (idx_q == head_i.last_idx);
  assign q_pop_o = load && at_end;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_take_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char <= head_i.chars[idx_q];
      out_q.run_last <= at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_refill_idle_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty && !out_valid_q |=> out_valid_q)
    else $error("output register not refilled from a waiting token");
  a_idx_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty |-> idx_q <= head_i.last_idx)
    else $error("character index ran past the token length");
`endif

endmodule

// ----- hw/rtl/c_string_escaper_core.sv -----
// c string escaper core
// turns a stream of raw string bytes into the text of a c string literal
// input channel: push / full, one beat is an in_item_t (byte plus last flag);
//   a beat is taken on a clock edge with push high and full low
// result channel: empty / pop, one beat is an out_item_t (one ascii char plus
//   run_last on the final char of a byte); the oldest char shows while empty
//   is low and leaves on an edge with pop high
// config channel: cfg_valid_i / cfg_ready_o, cfg_data_i is counted_mode;
//   ready is always high, write only while the block is idle
// path: byte tokens wait in a QDepth-deep token queue ahead of the output register
// throughput: the back end sends one char per cycle while pop stays high,
//   and a byte yields one, two or four chars (printable, simple escape or
//   counted nul, hex escape); a byte that yields nothing costs no back-end
//   time; the front classifies one byte per cycle while the queue is not full
// reset: queue and output register empty, counted_mode cleared, the string
//   is armed (not stopped)
// stall: when pop stays low the output register holds, the back end stops,
//   the queue fills and then full rises to hold off the sender
module c_string_escaper_core #(
  parameter int QDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cse_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output cse_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import cse_pkg::*;

  logic     counted_mode_q;
  logic     in_accept;
  logic     tok_push;
  token_t   tok;
  token_t   head;
  q_stat_t  q_stat;
  logic     q_pop;
  logic     out_valid;
  logic     stopped;

  // config register, taken on every valid beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counted_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      counted_mode_q <= cfg_data_i;
    end
  end

  // front end stalls only on a full token queue
  assign full      = q_stat.full;
  assign in_accept = push && !full;

  cse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .item_i         (in_item_i),
    .counted_mode_i (counted_mode_q),
    .tok_push_o     (tok_push),
    .tok_o          (tok),
    .stopped_o      (stopped)
  );

  // decouples classification from character output
  cse_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tok_push),
    .tok_i  (tok),
    .pop_i  (q_pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // serializes one token into characters through the output register
  cse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o),
    .out_take_i  (pop)
  );

  assign empty = !out_valid;

`ifndef NO_ASSERTIONS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_push |-> !q_stat.full)
    else $error("token pushed into a full queue");
  a_stopped_drops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && stopped |-> !tok_push)
    else $error("byte after string end produced output");
  a_stop_on_nul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !stopped && !counted_mode_q && !in_item_i.in_last &&
    in_item_i.in_byte == 8'h00 |=> stopped)
    else $error("terminating nul did not stop the string");
`endif

endmodule

// ----- bench/c_string_escaper_core_tb.sv -----
module c_string_escaper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;

  // bytes that take a simple escape: quote, double quote, question mark,
  // backslash, bell, backspace, form feed, newline, return, tab, vtab
  localparam logic [10:0][7:0] EscBytes = {
    8'h27, 8'h22, 8'h3F, 8'h5C, 8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B
  };
  localparam logic [7:0] ByteNul = 8'h00;

  // cycles for a byte that yields nothing to clear the front end and queue
  localparam int QuietCycles = 8;

  // counted_mode values
  localparam logic ModeTerminated = 1'b0;
  localparam logic ModeCounted    = 1'b1;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  in_item_t   in_item_i   = '0;
  logic       empty;
  logic       pop         = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i  = 1'b0;

  c_string_escaper_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // escaper state as the bench sees it
  logic      counted_q = ModeTerminated;
  logic      stopped_q = 1'b0;

  // characters still owed by the block, oldest first
  out_item_t pending_chars[$];
  out_item_t want_char;

  int errors         = 0;
  int bytes_sent     = 0;
  int bytes_escaped  = 0;
  int chars_checked  = 0;
  int nul_stops      = 0;
  int mode_writes    = 0;
  int burst_left     = 0;
  bit push_hi        = 1'b0;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'(8'h30 + nib) : 7'(8'h61 + nib - 4'd10);
  endfunction

  // escape one byte, queue its characters, return how many it made
  function automatic int escape_byte(input in_item_t it);
    logic [3:0][6:0] seq;
    logic [6:0]      letter;
    int              n;
    n = 0;
    seq = '0;
    case (it.in_byte)
      8'h27:   letter = 7'h27;
      8'h22:   letter = 7'h22;
      8'h3F:   letter = 7'h3F;
      8'h5C:   letter = 7'h5C;
      8'h07:   letter = 7'("a");
      8'h08:   letter = 7'("b");
      8'h0C:   letter = 7'("f");
      8'h0A:   letter = 7'("n");
      8'h0D:   letter = 7'("r");
      8'h09:   letter = 7'("t");
      8'h0B:   letter = 7'("v");
      default: letter = 7'h00;
    endcase
    if (!stopped_q) begin
      if (it.in_byte == ByteNul) begin
        if (counted_q == ModeCounted) begin
          seq[0] = CharBslash;
          seq[1] = CharZero;
          n = 2;
        end else begin
          // terminating nul: nothing out, rest of the string dropped
          stopped_q = 1'b1;
          nul_stops++;
        end
      end else if (letter != 7'h00) begin
        seq[0] = CharBslash;
        seq[1] = letter;
        n = 2;
      end else if (it.in_byte >= BytePrintLo && it.in_byte <= BytePrintHi) begin
        seq[0] = it.in_byte[6:0];
        n = 1;
      end else begin
        seq[0] = CharBslash;
        seq[1] = CharX;
        seq[2] = hex_char(it.in_byte[7:4]);
        seq[3] = hex_char(it.in_byte[3:0]);
        n = 4;
      end
    end
    for (int k = 0; k < n; k++) begin
      pending_chars.push_back('{out_char: seq[k], run_last: (k == n - 1)});
    end
    // last flag re-arms after the byte itself is handled
    if (it.in_last) begin
      stopped_q = 1'b0;
    end
    return n;
  endfunction

  // drop push (if held) and idle the sender for some cycles
  task automatic sender_rest(input int cycles);
    if (push_hi) begin
      push <= 1'b0;
      push_hi = 1'b0;
    end
    repeat (cycles) @(posedge clk_i);
  endtask

  // one input beat, in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_item_t it;
    it = '{in_byte: b, in_last: is_last};
    if (burst_left == 0) begin
      sender_rest($urandom_range(1, 8));
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    push <= 1'b1;
    push_hi = 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    bytes_sent++;
    if (escape_byte(it) > 0) begin
      bytes_escaped++;
    end
  endtask

  // hold off the sender until every owed character has come out
  task automatic wait_drain();
    sender_rest(1);
    while (pending_chars.size() != 0) @(posedge clk_i);
    // a dropped byte may still be in flight behind the last character
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    counted_q = mode;
    mode_writes++;
  endtask

  // random byte, weighted toward the interesting classes
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(19))
      0:               b = ByteNul;
      1, 2, 3:         b = EscBytes[$urandom_range(10)];
      4, 5:            b = 8'($urandom_range(1, 31));
      6, 7:            b = 8'($urandom_range(8'h7F, 8'hFF));
      8, 9:            b = 8'($urandom_range(255));
      default:         b = 8'($urandom_range(BytePrintLo, BytePrintHi));
    endcase
    return b;
  endfunction

  // reset mode: every byte class, then the terminating nul and re-arm
  task automatic test_terminated_mode();
    for (int i = 0; i < 11; i++) begin
      send_byte(EscBytes[i], 1'b0);
    end
    send_byte(8'h20, 1'b0);   // lowest printable
    send_byte(8'h7E, 1'b0);   // highest printable
    send_byte(8'h01, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h7F, 1'b0);   // del takes the hex form
    send_byte(8'h80, 1'b0);   // high half stays unsigned
    send_byte(8'hFF, 1'b0);
    send_byte(ByteNul, 1'b0); // ends the string
    send_byte(8'h41, 1'b0);   // dropped
    send_byte(8'hFF, 1'b1);   // dropped, but re-arms
    send_byte(ByteNul, 1'b1); // terminating nul that is also the last byte
    send_byte(8'h5A, 1'b1);
  endtask

  // counted mode: nul escapes as backslash zero
  task automatic test_counted_mode();
    write_mode(ModeCounted);
    send_byte(ByteNul, 1'b0);
    send_byte(ByteNul, 1'b1);
    send_byte(8'h30, 1'b1);
  endtask

  // mode change while the string is stopped keeps it stopped
  task automatic test_mode_change_stopped();
    write_mode(ModeTerminated);
    send_byte(8'h61, 1'b0);
    send_byte(ByteNul, 1'b0);
    write_mode(ModeCounted);
    send_byte(ByteNul, 1'b0); // still dropped
    send_byte(8'h62, 1'b1);   // dropped, re-arms
    send_byte(ByteNul, 1'b1); // now escaped
  endtask

  // random strings over several mode settings, some noise mixed in
  task automatic test_random_strings(input int per_phase);
    int start;
    int len;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_mode(ModeTerminated);
        1:       write_mode(ModeCounted);
        default: write_mode(1'($urandom_range(1)));
      endcase
      start = bytes_escaped;
      while (bytes_escaped - start < per_phase) begin
        if ($urandom_range(7) == 0) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            send_byte(pick_byte(), k == len - 1);
          end
        end
      end
    end
  endtask

  // receiver: runs of pops and runs of stalls of random length
  int  pop_left = 0;
  bit  pop_on   = 1'b1;
  always @(posedge clk_i) begin
    if (pop_left == 0) begin
      pop_on = !pop_on;
      pop_left = pop_on ? $urandom_range(1, 30) : $urandom_range(1, 8);
    end
    pop_left--;
    pop <= pop_on;
  end

  // check every character beat against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && pop && empty === 1'b0) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: out_char %h run_last %b",
               out_item_o.out_char, out_item_o.run_last);
        errors++;
      end else begin
        want_char = pending_chars.pop_front();
        if (out_item_o.out_char !== want_char.out_char) begin
          $error("out_char: expected %h, actual %h", want_char.out_char, out_item_o.out_char);
          errors++;
        end
        if (out_item_o.run_last !== want_char.run_last) begin
          $error("run_last: expected %b, actual %b", want_char.run_last, out_item_o.run_last);
          errors++;
        end
        chars_checked++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_terminated_mode();
    test_counted_mode();
    test_mode_change_stopped();
    test_random_strings(30);
    wait_drain();
    $display("sent %0d bytes (%0d escaped, %0d string-ending nuls), checked %0d characters",
             bytes_sent, bytes_escaped, nul_stops, chars_checked);
    $display("counted_mode written %0d times, both modes exercised", mode_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
